// File: src/isl_pkg.sv
// ----------------------------------------------------------------------------
// isl_pkg: shared types and codes for the indexed sequence list
// Holds the command and result payloads, command and status codes, the per-cell
// operation type, the control word broadcast to the cells and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package isl_pkg;

  // Width of count and position fields in the cell control word. It is wide
  // enough for the largest supported list depth (64 entries).
  localparam int CNT_W = 7;

  // Command codes.
  localparam logic [3:0] CMD_APPEND    = 4'd0;
  localparam logic [3:0] CMD_INS_FRONT = 4'd1;
  localparam logic [3:0] CMD_INS_BACK  = 4'd2;
  localparam logic [3:0] CMD_INS_POS   = 4'd3;
  localparam logic [3:0] CMD_DEL_FRONT = 4'd4;
  localparam logic [3:0] CMD_DEL_BACK  = 4'd5;
  localparam logic [3:0] CMD_DEL_POS   = 4'd6;
  localparam logic [3:0] CMD_READ_LAST = 4'd7;
  localparam logic [3:0] CMD_DUMP      = 4'd8;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  // Command payload.
  typedef struct packed {
    logic [3:0]         command;
    logic signed [31:0] value;
    logic [5:0]         position;
  } in_item_t;

  // Result payload.
  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
    logic               last_of_run;
  } out_item_t;

  // What every cell does in a given cycle.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE,
    OP_ROTATE
  } cell_op_t;

  // Control word broadcast along the chain.
  typedef struct packed {
    cell_op_t         op;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] cnt;
  } cell_ctl_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_OP,
    S_WALK
  } state_t;

endpackage

`default_nettype wire

// File: src/isl_cell.sv
// ----------------------------------------------------------------------------
// isl_cell: one entry of the list chain
// Holds a single value and, from the broadcast control word and its own
// index, takes the new value, a neighbour's value or the front value.
// ----------------------------------------------------------------------------
`default_nettype none

module isl_cell #(
  parameter int IDX = 0
) (
  input  wire                       clk,
  input  wire isl_pkg::cell_ctl_t   ctl,
  input  wire logic signed [31:0]   new_value,
  input  wire logic signed [31:0]   left_value,
  input  wire logic signed [31:0]   right_value,
  input  wire logic signed [31:0]   front_value,
  output logic signed [31:0]        value_out
);
  import isl_pkg::*;

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

  logic signed [31:0] value_r;
  logic signed [31:0] value_nxt;
  logic [CNT_W-1:0]   idx_plus1;

  assign idx_plus1 = IDX_C + CNT_W'(1);

  // Select the next value of this entry.
  always_comb begin
    value_nxt = value_r;
    case (ctl.op)
      OP_INSERT: begin
        if (IDX_C == ctl.pos) begin
          value_nxt = new_value;
        end else if (IDX_C > ctl.pos) begin
          value_nxt = left_value;
        end
      end
      OP_DELETE: begin
        if (IDX_C >= ctl.pos) begin
          value_nxt = right_value;
        end
      end
      OP_ROTATE: begin
        // The last valid entry takes the front value, the entries before it move forward.
        if (idx_plus1 == ctl.cnt) begin
          value_nxt = front_value;
        end else if (idx_plus1 < ctl.cnt) begin
          value_nxt = right_value;
        end
      end
      default: begin
        value_nxt = value_r;
      end
    endcase
  end

  // Entry storage; payload only, so no reset.
  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value_out = value_r;

endmodule

`default_nettype wire

// File: src/indexed_sequence_list.sv
// ----------------------------------------------------------------------------
// indexed_sequence_list: ordered list of signed 32-bit values
// A chain of cells that shift left or right to insert or delete at any
// position, and rotate through the front to read the list in order.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                     Handshake
//   --------  ------------------------  ------------------------------------
//   command   start, busy, in_item      transfer when start high, busy low
//   result    out_strobe, out_result    one cycle per result, no back-pressure
//
// Insert, delete and every command that fails take 2 cycles: the cycle of
// the transfer plus one cycle in which the whole chain shifts at once.
// Read-last and dump of a non-empty list take 2 + count cycles: the chain is
// rotated once through the front cell, count steps, which also restores it.
// The result register is loaded at the end of the work cycle, so its strobe
// overlaps the first idle cycle. Synchronous active-low reset empties the
// list; entry contents are not cleared. The receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_sequence_list #(
  parameter int DEPTH = 32
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   start,
  output logic                  busy,
  input  wire isl_pkg::in_item_t in_item,
  output logic                  out_strobe,
  output isl_pkg::out_item_t    out_result
);
  import isl_pkg::*;

  localparam int               CW      = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  state_t             state_r;
  state_t             state_nxt;
  in_item_t           cmd_r;
  in_item_t           cmd_nxt;
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      count_nxt;
  logic [CW-1:0]      walk_r;
  logic [CW-1:0]      walk_nxt;
  logic               strobe_r;
  logic               strobe_nxt;
  out_item_t          out_r;
  out_item_t          out_nxt;
  cell_ctl_t          ctl;
  logic [CNT_W-1:0]   cnt_ext;
  logic [CNT_W-1:0]   pos_ext;
  logic [CNT_W-1:0]   ins_pos;
  logic [CNT_W-1:0]   del_pos;
  logic               is_walk_cmd;
  logic               walk_last;
  logic signed [31:0] cell_val  [DEPTH];
  logic signed [31:0] left_val  [DEPTH];
  logic signed [31:0] right_val [DEPTH];

  assign cnt_ext     = CNT_W'(count_r);
  assign pos_ext     = CNT_W'(cmd_r.position);
  assign is_walk_cmd = (cmd_r.command == CMD_READ_LAST) || (cmd_r.command == CMD_DUMP);
  assign walk_last   = ((CNT_W'(walk_r) + CNT_W'(1)) == cnt_ext);

  // Position that the command works on.
  always_comb begin
    case (cmd_r.command)
      CMD_INS_FRONT: ins_pos = '0;
      CMD_INS_POS:   ins_pos = pos_ext;
      default:       ins_pos = cnt_ext;
    endcase
    case (cmd_r.command)
      CMD_DEL_FRONT: del_pos = '0;
      CMD_DEL_BACK:  del_pos = cnt_ext - CNT_W'(1);
      default:       del_pos = pos_ext;
    endcase
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_OP;
        end
      end
      S_OP: begin
        if (is_walk_cmd && (count_r != '0)) begin
          state_nxt = S_WALK;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_WALK: begin
        if (walk_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output logic: cell control, status and result words, counters.
  always_comb begin
    busy       = (state_r != S_IDLE);
    ctl.op     = OP_HOLD;
    ctl.pos    = '0;
    ctl.cnt    = cnt_ext;
    cmd_nxt    = cmd_r;
    count_nxt  = count_r;
    walk_nxt   = walk_r;
    strobe_nxt = 1'b0;
    out_nxt    = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt = in_item;
        end
      end
      S_OP: begin
        strobe_nxt          = 1'b1;
        out_nxt.last_of_run = 1'b1;
        out_nxt.status      = ST_RANGE;
        case (cmd_r.command)
          CMD_APPEND, CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_POS: begin
            if (ins_pos > cnt_ext) begin
              out_nxt.status = ST_RANGE;
            end else if (cnt_ext >= DEPTH_C) begin
              out_nxt.status = ST_FULL;
            end else begin
              out_nxt.status = ST_OK;
              ctl.op         = OP_INSERT;
              ctl.pos        = ins_pos;
              count_nxt      = count_r + CW'(1);
            end
          end
          CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_POS: begin
            if (count_r == '0) begin
              out_nxt.status = ST_EMPTY;
            end else if (del_pos >= cnt_ext) begin
              out_nxt.status = ST_RANGE;
            end else begin
              out_nxt.status = ST_OK;
              ctl.op         = OP_DELETE;
              ctl.pos        = del_pos;
              count_nxt      = count_r - CW'(1);
            end
          end
          CMD_READ_LAST, CMD_DUMP: begin
            if (count_r == '0) begin
              out_nxt.status = ST_EMPTY;
            end else begin
              // Results come from the rotation that follows.
              strobe_nxt = 1'b0;
              walk_nxt   = '0;
            end
          end
          default: begin
            out_nxt.status = ST_RANGE;
          end
        endcase
      end
      S_WALK: begin
        // Rotate once per cycle and read the entry leaving the front.
        ctl.op               = OP_ROTATE;
        strobe_nxt           = (cmd_r.command == CMD_DUMP) || walk_last;
        out_nxt.result_value = cell_val[0];
        out_nxt.status       = ST_OK;
        out_nxt.last_of_run  = walk_last;
        walk_nxt             = walk_r + CW'(1);
      end
      default: begin
        ctl.op = OP_HOLD;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    walk_r <= walk_nxt;
    out_r  <= out_nxt;
  end

  // Chain of cells, front at index zero.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_left_end
      assign left_val[g] = '0;
    end else begin : g_left
      assign left_val[g] = cell_val[g-1];
    end
    if (g == DEPTH - 1) begin : g_right_end
      assign right_val[g] = '0;
    end else begin : g_right
      assign right_val[g] = cell_val[g+1];
    end

    isl_cell #(
      .IDX (g)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .new_value   (cmd_r.value),
      .left_value  (left_val[g]),
      .right_value (right_val[g]),
      .front_value (cell_val[0]),
      .value_out   (cell_val[g])
    );
  end

  assign out_strobe = strobe_r;
  assign out_result = out_r;

endmodule

`default_nettype wire
